@@ design/rast_pkg.sv @@
package rast_pkg;

	// width of element values, sums and pending adds
	localparam int DATA_W = 64;

	// input field widths
	localparam int CMD_W   = 2;
	localparam int FIELD_W = 17;
	localparam int ADD_W   = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SUM   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	// unused code, accepted and ignored
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	// element count after reset
	localparam logic [FIELD_W-1:0] COUNT_RESET = 17'h10000;

endpackage

@@ design/rast_ram.sv @@
module rast_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ design/rast_mul.sv @@
module rast_mul import rast_pkg::*; #(
	parameter int NW = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] mcand,
	input  logic [NW-1:0]     mplier,
	output logic              done,
	output logic [DATA_W-1:0] prod
);

	localparam int CNW = $clog2(NW);

	logic              run_q;
	logic              done_q;
	logic [CNW-1:0]    cnt_q;
	logic [DATA_W-1:0] mc_q;
	logic [NW-1:0]     mp_q;
	logic [DATA_W-1:0] prod_q;

	// control: one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNW'(NW - 1);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift-add datapath, product wraps at the data width
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q   <= mcand;
			mp_q   <= mplier;
			prod_q <= '0;
		end else if (run_q) begin
			if (mp_q[0]) begin
				prod_q <= prod_q + mc_q;
			end
			mc_q <= {mc_q[DATA_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[NW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

@@ design/range_add_range_sum_tree.sv @@
// Range add and range sum over two Fenwick trees (B1, B2) in on-chip RAM.
// Add and sum walk the trees node by node, with IW = clog2(MAX_ELEMENTS+1);
// each tree node is read in S_RD and then written or accumulated in S_WR,
// and each 64-bit product comes from the IW-bit shift-add multiplier.
// Clear sweeps all MAX_ELEMENTS+1 RAM rows, one row per cycle; one item at a time.
// After reset the same clearing sweep runs before the first item is accepted.
module range_add_range_sum_tree import rast_pkg::*; #(
	parameter int MAX_ELEMENTS = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [FIELD_W-1:0]       element_count,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [FIELD_W-1:0]       range_low,
	input  logic [FIELD_W-1:0]       range_high,
	input  logic signed [ADD_W-1:0]  add_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] range_sum
);

	localparam int IW = $clog2(MAX_ELEMENTS + 1);
	localparam int XW = IW + 1;
	localparam int CW = ((IW > FIELD_W) ? IW : FIELD_W) + 1;
	localparam logic [IW-1:0] N_IDX = IW'(MAX_ELEMENTS);
	localparam logic [CW-1:0] N_CMP = CW'(MAX_ELEMENTS);

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_MUL, S_RD, S_WR, S_OUT} state_t;
	typedef enum logic [1:0] {ST_ADD_LO, ST_ADD_HI, ST_SUM_HI, ST_SUM_LO} step_t;

	state_t            state_q;
	step_t             step_q;
	logic [FIELD_W-1:0] count_q;
	logic [XW-1:0]     idx_q;
	logic [IW-1:0]     a_q;
	logic [IW-1:0]     b_q;
	logic [DATA_W-1:0] v_q;
	logic [DATA_W-1:0] d1_q;
	logic [DATA_W-1:0] d2_q;
	logic [DATA_W-1:0] acc1_q;
	logic [DATA_W-1:0] acc2_q;
	logic [DATA_W-1:0] res_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_sum_q;
	logic              mul_start_q;
	logic [DATA_W-1:0] mul_a_q;
	logic [IW-1:0]     mul_b_q;

	logic              mul_done;
	logic [DATA_W-1:0] mul_prod;
	logic              ram_we;
	logic [IW-1:0]     ram_addr;
	logic [DATA_W-1:0] wd1, wd2, rd1, rd2;
	logic              upd_mode;
	logic [XW-1:0]     lowbit, nxt_up, nxt_dn;
	logic [CW-1:0]     lim, lo_c, hi_c;
	logic              empty;
	logic [DATA_W-1:0] v_ext;
	logic              mul_go;
	logic              out_load;

	// clip the incoming range to 1..min(element_count, MAX_ELEMENTS)
	always_comb begin
		lim   = (CW'(count_q) > N_CMP) ? N_CMP : CW'(count_q);
		lo_c  = (range_low == '0) ? CW'(1) : CW'(range_low);
		hi_c  = (CW'(range_high) > lim) ? lim : CW'(range_high);
		empty = (lim == '0) || (lo_c > hi_c);
		v_ext = DATA_W'(add_value);
	end

	// Fenwick index stepping
	assign lowbit   = idx_q & (~idx_q + 1'b1);
	assign nxt_up   = idx_q + lowbit;
	assign nxt_dn   = idx_q - lowbit;
	assign upd_mode = (step_q == ST_ADD_LO) || (step_q == ST_ADD_HI);

	// multiplier start: add accepted, low update walk done, prefix walk done
	assign mul_go = ((state_q == S_IDLE) && in_valid && (command == CMD_ADD) && !empty)
		|| ((state_q == S_WR) && upd_mode && (nxt_up > {1'b0, N_IDX})
			&& (step_q == ST_ADD_LO) && (b_q < N_IDX))
		|| ((state_q == S_WR) && !upd_mode && (nxt_dn == '0));

	// output register loads when free or draining
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// RAM port: clearing sweep, read-modify-write of one node, or a plain read in the prefix walk
	assign ram_addr = idx_q[IW-1:0];
	assign ram_we   = (state_q == S_CLR) || ((state_q == S_WR) && upd_mode);
	assign wd1      = (state_q == S_CLR) ? '0 : rd1 + d1_q;
	assign wd2      = (state_q == S_CLR) ? '0 : rd2 + d2_q;

	rast_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS + 1)) u_b1 (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wd1), .rdata(rd1)
	);

	rast_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS + 1)) u_b2 (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wd2), .rdata(rd2)
	);

	rast_mul #(.NW(IW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .mcand(mul_a_q),
		.mplier(mul_b_q), .done(mul_done), .prod(mul_prod)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign range_sum = out_sum_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			step_q      <= ST_ADD_LO;
			count_q     <= COUNT_RESET;
			idx_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			v_q         <= '0;
			d1_q        <= '0;
			d2_q        <= '0;
			acc1_q      <= '0;
			acc2_q      <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_sum_q   <= '0;
			mul_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
		end else begin
			mul_start_q <= mul_go;
			if (cfg_valid) begin
				count_q <= element_count;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_sum_q   <= res_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q[IW-1:0] == N_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						a_q <= lo_c[IW-1:0];
						b_q <= hi_c[IW-1:0];
						v_q <= v_ext;
						case (command)
							CMD_ADD: begin
								if (!empty) begin
									step_q      <= ST_ADD_LO;
									mul_a_q     <= v_ext;
									mul_b_q     <= lo_c[IW-1:0] - 1'b1;
									state_q     <= S_MUL;
								end
							end
							CMD_SUM: begin
								if (empty) begin
									res_q   <= '0;
									state_q <= S_OUT;
								end else begin
									step_q  <= ST_SUM_HI;
									acc1_q  <= '0;
									acc2_q  <= '0;
									idx_q   <= XW'(hi_c[IW-1:0]);
									state_q <= S_RD;
								end
							end
							CMD_CLEAR: begin
								idx_q   <= '0;
								state_q <= S_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				S_MUL: begin
					if (mul_done) begin
						case (step_q)
							ST_ADD_LO: begin
								d1_q    <= v_q;
								d2_q    <= mul_prod;
								idx_q   <= XW'(a_q);
								state_q <= S_RD;
							end
							ST_ADD_HI: begin
								d1_q    <= '0 - v_q;
								d2_q    <= '0 - mul_prod;
								idx_q   <= XW'(b_q) + 1'b1;
								state_q <= S_RD;
							end
							ST_SUM_HI: begin
								res_q <= mul_prod - acc2_q;
								if (a_q == IW'(1)) begin
									state_q <= S_OUT;
								end else begin
									step_q  <= ST_SUM_LO;
									acc1_q  <= '0;
									acc2_q  <= '0;
									idx_q   <= XW'(a_q - 1'b1);
									state_q <= S_RD;
								end
							end
							default: begin
								res_q   <= res_q - (mul_prod - acc2_q);
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (upd_mode) begin
						// point update walks up towards the last index
						idx_q <= nxt_up;
						if (nxt_up > {1'b0, N_IDX}) begin
							if (step_q == ST_ADD_LO && b_q < N_IDX) begin
								step_q      <= ST_ADD_HI;
								mul_a_q     <= v_q;
								mul_b_q     <= b_q;
								state_q     <= S_MUL;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							state_q <= S_RD;
						end
					end else begin
						// prefix walk strips the lowest set bit
						acc1_q <= acc1_q + rd1;
						acc2_q <= acc2_q + rd2;
						idx_q  <= nxt_dn;
						if (nxt_dn == '0) begin
							mul_a_q     <= acc1_q + rd1;
							mul_b_q     <= (step_q == ST_SUM_HI) ? b_q : a_q - 1'b1;
							state_q     <= S_MUL;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// node reads never touch row zero
	a_rd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> idx_q != '0)
		else $error("tree walk at index zero");

	// every node visited lies inside the tree
	a_rd_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> idx_q <= {1'b0, N_IDX})
		else $error("tree walk beyond last index");

	// products are only taken while the sequencer waits for them
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == S_MUL)
		else $error("product finished outside multiply step");

	// a result is loaded only into a free or draining output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_valid_q && !out_ready |=> out_valid_q && state_q == S_OUT)
		else $error("pending item overwritten");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import rast_pkg::*;

	localparam int TREE_SPAN = 65536;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [FIELD_W-1:0]      lo;
		logic [FIELD_W-1:0]      hi;
		logic signed [ADD_W-1:0] val;
	} tree_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [FIELD_W-1:0] element_count = COUNT_RESET;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = CMD_ADD;
	logic [FIELD_W-1:0] range_low = '0;
	logic [FIELD_W-1:0] range_high = '0;
	logic signed [ADD_W-1:0] add_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] range_sum;

	range_add_range_sum_tree dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .element_count(element_count),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.range_low(range_low), .range_high(range_high), .add_value(add_value),
		.out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow state: two fenwick trees give range add and range sum
	logic [DATA_W-1:0] fen_lin [1:TREE_SPAN];
	logic [DATA_W-1:0] fen_off [1:TREE_SPAN];
	logic [FIELD_W-1:0] live_count = COUNT_RESET;

	tree_cmd_t pending_cmds[$];
	logic [DATA_W-1:0] sums_due[$];
	int errors = 0;
	int accepted = 0;
	int cycle_no = 0;
	int hold_left = 0;
	bit hold_done = 0;

	// append an item to the stimulus queue
	function automatic void add_item(tree_cmd_t t);
		pending_cmds.insert(pending_cmds.size(), t);
	endfunction

	// append a sum to the expected results
	function automatic void expect_sum(logic [DATA_W-1:0] s);
		sums_due.insert(sums_due.size(), s);
	endfunction

	function automatic void fen_add(int pos, logic [DATA_W-1:0] dl, logic [DATA_W-1:0] dof);
		int i;
		i = pos;
		while (i <= TREE_SPAN) begin
			fen_lin[i] += dl;
			fen_off[i] += dof;
			i += i & (-i);
		end
	endfunction

	function automatic logic [DATA_W-1:0] prefix_sum(int pos);
		logic [DATA_W-1:0] sl, so;
		int i;
		sl = '0;
		so = '0;
		i = pos;
		while (i > 0) begin
			sl += fen_lin[i];
			so += fen_off[i];
			i -= i & (-i);
		end
		return sl * 64'(pos) - so;
	endfunction

	function automatic void wipe_tree();
		for (int i = 1; i <= TREE_SPAN; i++) begin
			fen_lin[i] = '0;
			fen_off[i] = '0;
		end
	endfunction

	// apply one item to the shadow state, queue the sum it should produce
	function automatic void predict_item(tree_cmd_t t);
		int lim, a, b;
		logic [DATA_W-1:0] v;
		lim = (live_count > TREE_SPAN) ? TREE_SPAN : int'(live_count);
		a = (t.lo < 1) ? 1 : int'(t.lo);
		b = (int'(t.hi) > lim) ? lim : int'(t.hi);
		v = {{(DATA_W-ADD_W){t.val[ADD_W-1]}}, t.val};
		if (t.cmd == CMD_CLEAR) begin
			wipe_tree();
		end else if (t.cmd == CMD_ADD) begin
			if (lim != 0 && a <= b) begin
				fen_add(a, v, v * 64'(a - 1));
				if (b + 1 <= TREE_SPAN) fen_add(b + 1, -v, -(v * 64'(b)));
			end
		end else if (t.cmd == CMD_SUM) begin
			if (lim == 0 || a > b) expect_sum('0);
			else expect_sum(prefix_sum(b) - prefix_sum(a - 1));
		end
	endfunction

	function automatic bit quiet_stretch();
		return cycle_no >= 150000 && cycle_no < 200000;
	endfunction

	// driver: one item offered at a time, held until accepted
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_item(tree_cmd_t'{command, range_low, range_high, add_value});
				accepted <= accepted + 1;
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_cmds.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 6)) begin
					tree_cmd_t t;
					t = pending_cmds.pop_front();
					in_valid <= 1'b1;
					command <= t.cmd;
					range_low <= t.lo;
					range_high <= t.hi;
					add_value <= t.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: back-pressure and comparison against the oldest expected sum
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (sums_due.size() == 0) begin
					$display("%0t: unexpected sum, expected none, actual %0d", $time, range_sum);
					errors++;
				end else begin
					logic [DATA_W-1:0] want;
					want = sums_due.pop_front();
					if (want !== range_sum) begin
						$display("%0t: range_sum mismatch, expected %0d, actual %0d",
							$time, $signed(want), range_sum);
						errors++;
					end
				end
			end
			if (!hold_done && accepted >= 400) begin
				hold_done <= 1;
				hold_left <= 3000;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet_stretch() || $urandom_range(99) >= 6;
			end
		end
	end

	function automatic tree_cmd_t random_cmd(int lim);
		tree_cmd_t t;
		int r, span;
		span = (lim == 0) ? 16 : lim;
		r = $urandom_range(999);
		if (r < 3) t.cmd = CMD_CLEAR;
		else if (r < 15) t.cmd = CMD_NOP;
		else if (r < 510) t.cmd = CMD_ADD;
		else t.cmd = CMD_SUM;
		if ($urandom_range(9) == 0) begin
			t.lo = FIELD_W'($urandom);
			t.hi = FIELD_W'($urandom);
		end else begin
			t.lo = FIELD_W'($urandom_range(1, span));
			t.hi = FIELD_W'($urandom_range(int'(t.lo), span));
			if ($urandom_range(19) == 0) t.hi = FIELD_W'(span + $urandom_range(1, 50));
		end
		t.val = $urandom;
		return t;
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || sums_due.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_count(logic [FIELD_W-1:0] v);
		cfg_valid <= 1'b1;
		element_count <= v;
		do @(posedge clk); while (!cfg_ready);
		live_count = v;
		cfg_valid <= 1'b0;
	endtask

	// stimulus: directed items, then phases of random items under several counts
	initial begin
		logic [FIELD_W-1:0] counts [6];
		int lim;
		counts = '{17'd1, 17'd0, 17'h1FFFF, 17'd100, 17'd65536, 17'd777};
		wipe_tree();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_item(tree_cmd_t'{CMD_ADD, 17'd1, 17'd65536, 32'sh7FFFFFFF});
		add_item(tree_cmd_t'{CMD_ADD, 17'd1, 17'd65536, 32'sh7FFFFFFF});
		add_item(tree_cmd_t'{CMD_SUM, 17'd1, 17'd65536, 32'sd0});
		add_item(tree_cmd_t'{CMD_ADD, 17'd0, 17'h1FFFF, -32'sh80000000});
		add_item(tree_cmd_t'{CMD_SUM, 17'd1, 17'd1, 32'sd0});
		add_item(tree_cmd_t'{CMD_SUM, 17'd65536, 17'd65536, 32'sd0});
		add_item(tree_cmd_t'{CMD_SUM, 17'd0, 17'h1FFFF, 32'sd0});
		add_item(tree_cmd_t'{CMD_ADD, 17'd500, 17'd400, 32'sd99});
		add_item(tree_cmd_t'{CMD_SUM, 17'd500, 17'd400, 32'sd0});
		add_item(tree_cmd_t'{CMD_ADD, 17'd65537, 17'h1FFFF, 32'sd5});
		add_item(tree_cmd_t'{CMD_SUM, 17'd65537, 17'h1FFFF, 32'sd0});
		add_item(tree_cmd_t'{CMD_NOP, 17'd1, 17'd10, 32'sd3});
		add_item(tree_cmd_t'{CMD_ADD, 17'd3, 17'd7, -32'sd1});
		add_item(tree_cmd_t'{CMD_SUM, 17'd2, 17'd8, 32'sd0});
		add_item(tree_cmd_t'{CMD_CLEAR, 17'd0, 17'd0, 32'sd0});
		add_item(tree_cmd_t'{CMD_SUM, 17'd1, 17'd65536, 32'sd0});
		for (int i = 0; i < 300; i++) add_item(random_cmd(65536));
		add_item(tree_cmd_t'{CMD_SUM, 17'd1, 17'd65536, 32'sd0});
		wait_drained();
		foreach (counts[k]) begin
			write_count(counts[k]);
			lim = (counts[k] > TREE_SPAN) ? TREE_SPAN : int'(counts[k]);
			for (int i = 0; i < 250; i++) add_item(random_cmd(lim));
			// a closing sum makes sure the block is idle before the next write
			add_item(tree_cmd_t'{CMD_SUM, 17'd1, 17'd65536, 32'sd0});
			wait_drained();
		end
		if (errors == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
